### hdl/cdsn_pkg.sv
// Shared types, constants and calendar helper functions for the date stepper.
// Used by the controller, the datapath and the port checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdsn_pkg;

    // Limits of the stepper
    localparam int COUNT_MAX  = 65535;
    localparam int YEAR_MAX   = 65535;
    localparam int CNT_W      = $clog2(COUNT_MAX + 1);
    localparam int YEAR_W     = 16;
    localparam int RESET_YEAR = 1901;

    // Year mod 400 reduction: subtract 400 << k for k = MOD_STEPS-1 .. 0
    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int MOD_STEPS  = 8;
    localparam int K_W        = $clog2(MOD_STEPS);
    localparam int REM_W      = $clog2(LEAP_CYCLE);

    // Month codes
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Month lengths
    localparam logic [4:0] DAYS_28 = 5'd28;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_31 = 5'd31;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new item
        logic mod_step;  // one year mod 400 reduction step
        logic check;     // validate the starting date
        logic step;      // move one day, forward or backward
        logic out_load;  // move the result into the output register
    } cdsn_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mod_last;  // last reduction step in progress
        logic date_ok;   // starting date is valid
        logic step_done; // no days left or the year left its range
    } cdsn_stat_t;

    // Gregorian leap rule from year mod 400 and the two low year bits
    function automatic logic leap_year(input logic [REM_W-1:0] rem,
                                       input logic [1:0] ylo);
        logic cent;
        cent = (rem == REM_W'(CENTURY)) || (rem == REM_W'(2 * CENTURY)) ||
               (rem == REM_W'(3 * CENTURY));
        return (rem == '0) || ((ylo == 2'b00) && !cent);
    endfunction

    // Days in a month; out-of-range months read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MON_FEB: len = leap ? DAYS_29 : DAYS_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
            default: len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### hdl/cdsn_ctrl.sv
// Sequencing state machine of the date stepper.
// Depends on cdsn_pkg; drives the datapath commands and both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module cdsn_ctrl
    import cdsn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire cdsn_stat_t stat,
    output cdsn_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.date_ok ? ST_STEP : ST_FIN;
            end
            ST_STEP:
            begin
                if (stat.step_done)
                    state_next = ST_FIN;
                else
                    cmd.step = 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/cdsn_dp.sv
// Datapath of the date stepper: date registers, year mod 400 reducer,
// validity check, one-day step logic and the output register.
// Depends on cdsn_pkg; commanded by cdsn_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cdsn_dp
    import cdsn_pkg::*;
(
    input  wire logic              clk,
    input  wire cdsn_cmd_t         cmd,
    output cdsn_stat_t             stat,
    input  wire logic              in_op,
    input  wire logic [4:0]        in_day,
    input  wire logic [3:0]        in_month,
    input  wire logic [YEAR_W-1:0] in_year,
    input  wire logic [15:0]       in_count,
    output logic [4:0]             out_day,
    output logic [3:0]             out_month,
    output logic [YEAR_W-1:0]      out_year,
    output logic                   out_ok
);

    localparam logic [YEAR_W-1:0] LEAP_CYCLE_Y = YEAR_W'(LEAP_CYCLE);
    localparam logic [REM_W-1:0]  REM_TOP      = REM_W'(LEAP_CYCLE - 1);

    logic              op_reg;
    logic [4:0]        day_reg, day_next;
    logic [3:0]        mon_reg, mon_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [YEAR_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              ovf_reg, ovf_next;
    logic              bad_reg, bad_next;
    logic [4:0]        out_day_reg;
    logic [3:0]        out_mon_reg;
    logic [YEAR_W-1:0] out_year_reg;
    logic              out_ok_reg;

    logic [YEAR_W-1:0] sub_val;
    logic [REM_W-1:0]  rem_lo;
    logic              leap;
    logic [4:0]        mlen;
    logic              date_ok;
    logic [CNT_W-1:0]  cnt_init;

    assign rem_lo  = rem_reg[REM_W-1:0];
    assign leap    = leap_year(rem_lo, year_reg[1:0]);
    assign mlen    = month_len(mon_reg, leap);
    assign sub_val = LEAP_CYCLE_Y << k_reg;

    // Starting date check
    assign date_ok = (mon_reg >= MON_JAN) && (mon_reg <= MON_DEC) &&
                     (year_reg != '0) &&
                     ({1'b0, year_reg} <= (YEAR_W + 1)'(YEAR_MAX)) &&
                     (day_reg != '0) && (day_reg <= mlen);

    // Count saturation
    assign cnt_init = (32'(in_count) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(in_count);

    assign stat.mod_last  = (k_reg == '0);
    assign stat.date_ok   = date_ok;
    assign stat.step_done = (cnt_reg == '0) || ovf_reg;

    // Next values of the working registers
    always_comb
    begin
        day_next  = day_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;
        if (cmd.load)
        begin
            day_next  = in_day;
            mon_next  = in_month;
            year_next = in_year;
            rem_next  = in_year;
            cnt_next  = cnt_init;
            k_next    = K_W'(MOD_STEPS - 1);
            ovf_next  = 1'b0;
            bad_next  = 1'b0;
        end
        else if (cmd.mod_step)
        begin
            // restoring reduction by 400 << k
            if (rem_reg >= sub_val)
                rem_next = rem_reg - sub_val;
            k_next = k_reg - K_W'(1);
        end
        else if (cmd.check)
        begin
            bad_next = !date_ok;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (!op_reg)
            begin
                // forward one day
                if (day_reg >= mlen)
                begin
                    day_next = 5'd1;
                    if (mon_reg == MON_DEC)
                    begin
                        mon_next = MON_JAN;
                        if (year_reg == YEAR_W'(YEAR_MAX))
                            ovf_next = 1'b1;
                        else
                        begin
                            year_next = year_reg + YEAR_W'(1);
                            rem_next  = (rem_lo == REM_TOP) ? '0
                                      : YEAR_W'(rem_lo) + YEAR_W'(1);
                        end
                    end
                    else
                        mon_next = mon_reg + 4'd1;
                end
                else
                    day_next = day_reg + 5'd1;
            end
            else
            begin
                // backward one day; December is 31 days whatever the year
                if (day_reg == 5'd1)
                begin
                    if (mon_reg == MON_JAN)
                    begin
                        mon_next = MON_DEC;
                        day_next = DAYS_31;
                        if (year_reg == YEAR_W'(1))
                            ovf_next = 1'b1;
                        else
                        begin
                            year_next = year_reg - YEAR_W'(1);
                            rem_next  = (rem_lo == '0) ? YEAR_W'(REM_TOP)
                                      : YEAR_W'(rem_lo) - YEAR_W'(1);
                        end
                    end
                    else
                    begin
                        mon_next = mon_reg - 4'd1;
                        day_next = month_len(mon_reg - 4'd1, leap);
                    end
                end
                else
                    day_next = day_reg - 5'd1;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= in_op;
        day_reg  <= day_next;
        mon_reg  <= mon_next;
        year_reg <= year_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        ovf_reg  <= ovf_next;
        bad_reg  <= bad_next;
    end

    // Output register; a failed item reads as 1 January 1901
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (bad_reg || ovf_reg)
            begin
                out_day_reg  <= 5'd1;
                out_mon_reg  <= MON_JAN;
                out_year_reg <= YEAR_W'(RESET_YEAR);
                out_ok_reg   <= 1'b0;
            end
            else
            begin
                out_day_reg  <= day_reg;
                out_mon_reg  <= mon_reg;
                out_year_reg <= year_reg;
                out_ok_reg   <= 1'b1;
            end
        end
    end

    assign out_day   = out_day_reg;
    assign out_month = out_mon_reg;
    assign out_year  = out_year_reg;
    assign out_ok    = out_ok_reg;

endmodule

`default_nettype wire

### hdl/calendar_date_step_n_days_core.sv
// Gregorian date stepper, top level: steps a date by up to COUNT_MAX days.
// The year is reduced mod 400 in MOD_STEPS restoring steps, the starting date is checked,
// then the single day-step unit steps one day at a time until the count runs out
// or the year leaves its range; an invalid starting date skips the stepping.
// One item at a time: the next item is taken once the result is in the output register.
// Reset (rst_n, async, active low) idles the controller and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_step_n_days_core
    import cdsn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // day[4:0], month[8:5], year[24:9], count[40:25]
    input  wire logic        s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // out_day[4:0], out_month[8:5], out_year[24:9]
    output logic             m_axis_tuser   // valid_res
);

    cdsn_cmd_t         cmd;
    cdsn_stat_t        stat;
    logic [4:0]        out_day;
    logic [3:0]        out_month;
    logic [YEAR_W-1:0] out_year;
    logic              out_ok;

    // Sequencer
    cdsn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Date datapath
    cdsn_dp u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser),
        .in_day    (s_axis_tdata[4:0]),
        .in_month  (s_axis_tdata[8:5]),
        .in_year   (s_axis_tdata[24:9]),
        .in_count  (s_axis_tdata[40:25]),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year),
        .out_ok    (out_ok)
    );

    // Result packing
    assign m_axis_tdata = {7'd0, out_year, out_month, out_day};
    assign m_axis_tuser = out_ok;

endmodule

`default_nettype wire

### hdl/cdsn_chk.sv
// Port-level checker for the date stepper, bound to the top level.
// Depends on cdsn_pkg and calendar_date_step_n_days_core.
`timescale 1ns / 1ps
`default_nettype none

module cdsn_chk
    import cdsn_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One item at a time: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // Failed items read as 1 January 1901
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[4:0] == 5'd1 && m_axis_tdata[8:5] == MON_JAN &&
            m_axis_tdata[24:9] == YEAR_W'(RESET_YEAR))
        else $error("bad result is not the reset date");

    // Good results carry a plausible date
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] >= MON_JAN &&
            m_axis_tdata[8:5] <= MON_DEC && m_axis_tdata[24:9] != '0)
        else $error("valid result with impossible date");

endmodule

bind calendar_date_step_n_days_core cdsn_chk u_chk (.*);

`default_nettype wire
